// ===== rtl/sv32_page_table_walker_core_macros.svh =====
// Assertion macros for the Sv32 page table walker checker
`ifndef SV32_PAGE_TABLE_WALKER_CORE_MACROS_SVH
`define SV32_PAGE_TABLE_WALKER_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SV32PTW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sv32ptw: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define SV32PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sv32ptw: next-cycle check failed");

`endif

// ===== rtl/sv32ptw_pkg.sv =====
// Types and constants shared by the Sv32 page table walker modules
package sv32ptw_pkg;

	localparam int WORD_W   = 32;
	localparam int VA_W     = 32;
	localparam int FRAME_W  = 20;
	localparam int FAULT_W  = 2;
	localparam int WIDX_W   = 30;   // word index of a 32-bit byte address
	localparam int VPN_W    = 10;
	localparam int FOLD_SHIFT = 30; // fixed-point shift of the reciprocal fold

	// entry bit positions
	localparam int ENT_V   = 0;
	localparam int ENT_A   = 6;
	localparam int ENT_D   = 7;
	localparam int PPN_LSB = 10;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_XLATE = 1'b1;

	typedef enum logic [FAULT_W-1:0] {
		FAULT_NONE = 2'd0,
		FAULT_DIR  = 2'd1,
		FAULT_LEAF = 2'd2
	} fault_t;

	typedef enum logic [1:0] {
		FOLD_LOAD,
		FOLD_DIR,
		FOLD_LEAF
	} fold_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FOLD0,
		ST_WAIT0,
		ST_LD_WR,
		ST_DIR_RD,
		ST_DIR_CHK,
		ST_FOLD1,
		ST_WAIT1,
		ST_LEAF_RD,
		ST_LEAF_CHK,
		ST_LEAF_UPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic      capture;
		logic      fold_start;
		fold_sel_t fold_sel;
		logic      ram_rd;
		logic      ram_wr;
		logic      wr_leaf;
		logic      entry_capture;
		logic      res_load;
		fault_t    res_fault;
		logic      res_updated;
		logic      out_push;
	} ctrl_cmd_t;

	typedef struct packed {
		logic fold_done;
		logic is_xlate;
		logic entry_valid;
		logic needs_update;
		logic out_free;
	} ctrl_status_t;

endpackage

// ===== rtl/sv32ptw_ifs.sv =====
// Channel interfaces: configuration write, request and response
interface sv32ptw_cfg_if;
	logic        valid;
	logic        ready;
	logic [19:0] root_page_number;

	modport source (output valid, output root_page_number, input ready);
	modport sink   (input valid, input root_page_number, output ready);
endinterface

interface sv32ptw_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] virtual_address;
	logic [31:0] table_word;
	logic        store_op;

	modport source (output valid, output command, output virtual_address,
		output table_word, output store_op, input ready);
	modport sink   (input valid, input command, input virtual_address,
		input table_word, input store_op, output ready);
endinterface

interface sv32ptw_rsp_if;
	logic        valid;
	logic        ready;
	logic [19:0] frame_number;
	logic [1:0]  fault;
	logic        entry_updated;

	modport source (output valid, output frame_number, output fault,
		output entry_updated, input ready);
	modport sink   (input valid, input frame_number, input fault,
		input entry_updated, output ready);
endinterface

// ===== rtl/sv32_page_table_walker_core.sv =====
// Sv32 two-level page table walker over a local single-port table store.
// A load folds its address and writes the word to the store. A translate folds, reads and
// checks the directory entry, then the leaf, updating its A/D bits; a fault ends the walk.
// A fold is a mask for a power-of-two STORE_WORDS, else a reciprocal multiply and correction.
// The response sits in an output register, so a new item is taken while it waits.
// arst_n clears the controller, the root register and the response valid; store is unset.
module sv32_page_table_walker_core
	import sv32ptw_pkg::*;
#(
	parameter int STORE_WORDS = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	sv32ptw_cfg_if.sink   cfg,
	sv32ptw_req_if.sink   req,
	sv32ptw_rsp_if.source rsp
);

	ctrl_cmd_t    cmd;
	ctrl_status_t status;
	logic         in_ready;

	assign cfg.ready = 1'b1;
	assign req.ready = in_ready;

	sv32ptw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sv32ptw_dp #(.STORE_WORDS(STORE_WORDS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg.valid),
		.cfg_root    (cfg.root_page_number),
		.in_command  (req.command),
		.in_va       (req.virtual_address),
		.in_word     (req.table_word),
		.in_store_op (req.store_op),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.out_frame   (rsp.frame_number),
		.out_fault   (rsp.fault),
		.out_updated (rsp.entry_updated)
	);

endmodule

// ===== rtl/sv32ptw_ram.sv =====
// Generic single-port RAM with registered read data
module sv32ptw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== rtl/sv32ptw_fold.sv =====
// Folds a 30-bit word index into the store: index modulo STORE_WORDS
module sv32ptw_fold
	import sv32ptw_pkg::*;
#(
	parameter int STORE_WORDS = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [WIDX_W-1:0]              widx,
	output logic                           done,
	output logic [$clog2(STORE_WORDS)-1:0] idx
);

	localparam int AW = $clog2(STORE_WORDS);

	generate
		if ((STORE_WORDS & (STORE_WORDS - 1)) == 0) begin : g_pow2
			logic [AW-1:0] lo_s1;
			logic          v_s1;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s1 <= 1'b0;
				end else begin
					v_s1 <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					lo_s1 <= widx[AW-1:0];
				end
			end

			assign done = v_s1;
			assign idx  = lo_s1;
		end else begin : g_recip
			// q = floor(w * floor(2^30 / S) / 2^30) is low by at most one,
			// so one compare and subtract finishes the remainder
			localparam int SW    = $clog2(STORE_WORDS + 1);
			localparam int RECIP = (1 << FOLD_SHIFT) / STORE_WORDS;
			localparam int MW    = $clog2(RECIP + 1);
			localparam int QW    = WIDX_W + 1 - AW;
			localparam int PW    = WIDX_W + MW;
			localparam int RW    = AW + 1;

			logic [WIDX_W-1:0] w_s1, w_s2;
			logic [QW-1:0]     q_s2;
			logic [RW-1:0]     r_s3;
			logic              v_s1, v_s2, v_s3;
			logic [PW-1:0]     prod;
			logic [QW+SW-1:0]  qs;
			logic [RW-1:0]     r_sub;

			assign prod  = PW'(w_s1) * PW'(RECIP);
			assign qs    = (QW+SW)'(q_s2) * (QW+SW)'(STORE_WORDS);
			assign r_sub = r_s3 - RW'(STORE_WORDS);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s1 <= 1'b0;
					v_s2 <= 1'b0;
					v_s3 <= 1'b0;
				end else begin
					v_s1 <= start;
					v_s2 <= v_s1;
					v_s3 <= v_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					w_s1 <= widx;
				end
				if (v_s1) begin
					w_s2 <= w_s1;
					q_s2 <= prod[FOLD_SHIFT +: QW];
				end
				if (v_s2) begin
					r_s3 <= RW'(w_s2 - WIDX_W'(qs));
				end
			end

			assign done = v_s3;
			assign idx  = (r_s3 >= RW'(STORE_WORDS)) ? r_sub[AW-1:0] : r_s3[AW-1:0];
		end
	endgenerate

endmodule

// ===== rtl/sv32ptw_ctrl.sv =====
// Walk controller: sequences folds, table reads, write-back and response
module sv32ptw_ctrl
	import sv32ptw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  ctrl_status_t status,
	output ctrl_cmd_t    cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_FOLD0;
			end
			ST_FOLD0:   state_nxt = ST_WAIT0;
			ST_WAIT0: begin
				if (status.fold_done) state_nxt = status.is_xlate ? ST_DIR_RD : ST_LD_WR;
			end
			ST_LD_WR:   state_nxt = ST_IDLE;
			ST_DIR_RD:  state_nxt = ST_DIR_CHK;
			ST_DIR_CHK: state_nxt = status.entry_valid ? ST_FOLD1 : ST_DONE;
			ST_FOLD1:   state_nxt = ST_WAIT1;
			ST_WAIT1: begin
				if (status.fold_done) state_nxt = ST_LEAF_RD;
			end
			ST_LEAF_RD:  state_nxt = ST_LEAF_CHK;
			ST_LEAF_CHK: state_nxt = status.entry_valid ? ST_LEAF_UPD : ST_DONE;
			ST_LEAF_UPD: state_nxt = ST_DONE;
			ST_DONE: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_FOLD0: begin
				cmd.fold_start = 1'b1;
				cmd.fold_sel   = status.is_xlate ? FOLD_DIR : FOLD_LOAD;
			end
			ST_LD_WR: begin
				cmd.ram_wr = 1'b1;
			end
			ST_DIR_RD, ST_LEAF_RD: begin
				cmd.ram_rd = 1'b1;
			end
			ST_DIR_CHK: begin
				cmd.entry_capture = status.entry_valid;
				cmd.res_load      = !status.entry_valid;
				cmd.res_fault     = FAULT_DIR;
			end
			ST_FOLD1: begin
				cmd.fold_start = 1'b1;
				cmd.fold_sel   = FOLD_LEAF;
			end
			ST_LEAF_CHK: begin
				cmd.entry_capture = status.entry_valid;
				cmd.res_load      = !status.entry_valid;
				cmd.res_fault     = FAULT_LEAF;
			end
			ST_LEAF_UPD: begin
				cmd.ram_wr      = status.needs_update;
				cmd.wr_leaf     = 1'b1;
				cmd.res_load    = 1'b1;
				cmd.res_fault   = FAULT_NONE;
				cmd.res_updated = status.needs_update;
			end
			ST_DONE: begin
				cmd.out_push = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/sv32ptw_dp.sv =====
// Walk datapath: item registers, address fold, table store and result registers
module sv32ptw_dp
	import sv32ptw_pkg::*;
#(
	parameter int STORE_WORDS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [FRAME_W-1:0] cfg_root,
	input  logic               in_command,
	input  logic [VA_W-1:0]    in_va,
	input  logic [WORD_W-1:0]  in_word,
	input  logic               in_store_op,
	input  ctrl_cmd_t          cmd,
	output ctrl_status_t       status,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [FRAME_W-1:0] out_frame,
	output logic [FAULT_W-1:0] out_fault,
	output logic               out_updated
);

	localparam int AW = $clog2(STORE_WORDS);

	logic [FRAME_W-1:0] root_q;
	logic               cmd_q;
	logic [VA_W-1:0]    va_q;
	logic [WORD_W-1:0]  word_q;
	logic               wr_q;
	logic [AW-1:0]      idx_q;
	logic [WORD_W-1:0]  entry_q;
	logic [FRAME_W-1:0] res_frame_q;
	fault_t             res_fault_q;
	logic               res_upd_q;
	logic               out_valid_q;
	logic [FRAME_W-1:0] out_frame_q;
	logic [FAULT_W-1:0] out_fault_q;
	logic               out_upd_q;

	logic [WIDX_W-1:0]  fold_w;
	logic               fold_done;
	logic [AW-1:0]      fold_idx;
	logic [WORD_W-1:0]  ram_wdata;
	logic [WORD_W-1:0]  ram_rdata;
	logic [WORD_W-1:0]  leaf_set;

	always_comb begin
		case (cmd.fold_sel)
			FOLD_LOAD: fold_w = va_q[VA_W-1:2];
			FOLD_DIR:  fold_w = {root_q, va_q[VA_W-1 -: VPN_W]};
			FOLD_LEAF: fold_w = {entry_q[PPN_LSB +: FRAME_W], va_q[VA_W-VPN_W-1 -: VPN_W]};
			default:   fold_w = va_q[VA_W-1:2];
		endcase
	end

	sv32ptw_fold #(.STORE_WORDS(STORE_WORDS)) u_fold (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.fold_start),
		.widx   (fold_w),
		.done   (fold_done),
		.idx    (fold_idx)
	);

	// leaf write-back always sets accessed, and dirty on a store
	always_comb begin
		leaf_set        = entry_q;
		leaf_set[ENT_A] = 1'b1;
		if (wr_q) leaf_set[ENT_D] = 1'b1;
	end

	assign ram_wdata = cmd.wr_leaf ? leaf_set : word_q;

	sv32ptw_ram #(.WIDTH(WORD_W), .DEPTH(STORE_WORDS)) u_store (
		.clk   (clk),
		.en    (cmd.ram_rd | cmd.ram_wr),
		.we    (cmd.ram_wr),
		.addr  (idx_q),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) root_q <= cfg_root;
			if (cmd.out_push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= in_command;
			va_q   <= in_va;
			word_q <= in_word;
			wr_q   <= in_store_op;
		end
		if (fold_done) idx_q <= fold_idx;
		if (cmd.entry_capture) entry_q <= ram_rdata;
		if (cmd.res_load) begin
			res_frame_q <= (cmd.res_fault == FAULT_NONE) ? entry_q[PPN_LSB +: FRAME_W] : '0;
			res_fault_q <= cmd.res_fault;
			res_upd_q   <= cmd.res_updated;
		end
		if (cmd.out_push) begin
			out_frame_q <= res_frame_q;
			out_fault_q <= res_fault_q;
			out_upd_q   <= res_upd_q;
		end
	end

	assign status.fold_done    = fold_done;
	assign status.is_xlate     = (cmd_q == CMD_XLATE);
	assign status.entry_valid  = ram_rdata[ENT_V];
	assign status.needs_update = !entry_q[ENT_A] || (wr_q && !entry_q[ENT_D]);
	assign status.out_free     = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_frame   = out_frame_q;
	assign out_fault   = out_fault_q;
	assign out_updated = out_upd_q;

endmodule

// ===== rtl/sv32ptw_checker.sv =====
// Port-level checker for the Sv32 page table walker, bound to the top level
`include "sv32_page_table_walker_core_macros.svh"

module sv32ptw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_command,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [19:0] rsp_frame_number,
	input logic [1:0]  rsp_fault,
	input logic        rsp_entry_updated
);

	// a stalled response stays put
	`SV32PTW_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`SV32PTW_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_frame_number) && $stable(rsp_fault) && $stable(rsp_entry_updated))
	// a walk is in progress right after a translate transfer
	`SV32PTW_ASSERT_NEXT(a_busy_after_xlate, clk, arst_n, req_valid && req_ready && req_command, !req_ready)
	// a response never appears on the cycle right after a request transfer
	`SV32PTW_ASSERT_SAME(a_no_instant_rsp, clk, arst_n, $rose(rsp_valid), !$past(req_valid && req_ready))

endmodule

bind sv32_page_table_walker_core sv32ptw_checker u_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_command       (req.command),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_frame_number  (rsp.frame_number),
	.rsp_fault         (rsp.fault),
	.rsp_entry_updated (rsp.entry_updated)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the Sv32 page table walker core
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sv32ptw_pkg::*;

	localparam int STORE_WORDS = 4096;
	localparam int RANDOM_ITEMS = 1930;
	localparam int PHASES = 6;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_AFTER = 400;
	localparam int HOLD_CYCLES = 500;
	localparam int IDLE_PCT = 28;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		fault_t             fault;
		logic               updated;
	} walk_result_t;

	typedef struct {
		logic         cmd;
		logic [31:0]  addr;
		logic [31:0]  word;
		logic         wr;
		bit           typed;
		walk_result_t want;
	} probe_row_t;

	localparam walk_result_t UNTYPED = '0;

	logic clk;
	logic arst_n;

	sv32ptw_cfg_if cfg_ch();
	sv32ptw_req_if req_ch();
	sv32ptw_rsp_if rsp_ch();

	sv32_page_table_walker_core #(.STORE_WORDS(STORE_WORDS)) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// shadow of the table store and the root register
	logic [31:0]  table_mirror [STORE_WORDS];
	bit           slot_loaded [STORE_WORDS];
	logic [19:0]  root_mirror = '0;
	walk_result_t pending_walks [$];
	logic [31:0]  recent_va [$];

	int unsigned mismatches = 0;
	int unsigned responses_seen = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	bit          calm = 1'b0;

	// root 0 after reset; loads at the extremes, folded and unaligned addresses
	probe_row_t probe_rows [19] = '{
		'{CMD_LOAD,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, UNTYPED},
		'{CMD_XLATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, '{20'h0, FAULT_DIR, 1'b0}},
		'{CMD_LOAD,  32'h0000_0FFC, 32'h0000_0401, 1'b1, 1'b0, UNTYPED},
		'{CMD_LOAD,  32'h0000_1000, 32'hFFFF_FC3E, 1'b0, 1'b0, UNTYPED},
		'{CMD_XLATE, 32'hFFC0_0000, 32'h0000_0000, 1'b1, 1'b1, '{20'h0, FAULT_LEAF, 1'b0}},
		'{CMD_LOAD,  32'h0000_1FFC, 32'hFFFF_FC01, 1'b0, 1'b0, UNTYPED},
		'{CMD_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, '{20'hFFFFF, FAULT_NONE, 1'b1}},
		'{CMD_XLATE, 32'hFFFF_F000, 32'hFFFF_FFFF, 1'b0, 1'b1, '{20'hFFFFF, FAULT_NONE, 1'b0}},
		'{CMD_XLATE, 32'hFFFF_F123, 32'h0000_0000, 1'b1, 1'b1, '{20'hFFFFF, FAULT_NONE, 1'b1}},
		'{CMD_XLATE, 32'hFFFF_FABC, 32'h0000_0000, 1'b1, 1'b1, '{20'hFFFFF, FAULT_NONE, 1'b0}},
		'{CMD_LOAD,  32'hFFFF_C004, 32'h0000_0001, 1'b0, 1'b0, UNTYPED},
		'{CMD_XLATE, 32'h0040_0000, 32'h0000_0000, 1'b0, 1'b1, '{20'h0, FAULT_LEAF, 1'b0}},
		'{CMD_LOAD,  32'h0000_0003, 32'h0000_00C1, 1'b1, 1'b0, UNTYPED},
		'{CMD_XLATE, 32'h0040_0FFF, 32'h0000_0000, 1'b1, 1'b1, '{20'h0, FAULT_NONE, 1'b0}},
		'{CMD_XLATE, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{20'h0, FAULT_NONE, 1'b0}},
		'{CMD_LOAD,  32'h0000_0008, 32'hABCD_E41F, 1'b0, 1'b0, UNTYPED},
		'{CMD_XLATE, 32'h0040_2000, 32'h0000_0000, 1'b1, 1'b0, UNTYPED},
		'{CMD_XLATE, 32'h0080_0000, 32'h0000_0000, 1'b0, 1'b0, UNTYPED},
		'{CMD_LOAD,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, UNTYPED}
	};

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	function automatic int unsigned slot_of(logic [31:0] byte_addr);
		return (byte_addr >> 2) % STORE_WORDS;
	endfunction

	function automatic logic [31:0] dir_addr_of(logic [19:0] root, logic [31:0] va);
		return {root, 12'h000} + {20'h0, va[31:22], 2'b00};
	endfunction

	// only the low 20 ppn bits survive the shift into a 32-bit address
	function automatic logic [31:0] leaf_addr_of(logic [31:0] pde, logic [31:0] va);
		return {pde[PPN_LSB +: FRAME_W], 12'h000} + {20'h0, va[21:12], 2'b00};
	endfunction

	// byte address with random upper bits and low bits that still lands on slot
	function automatic logic [31:0] addr_for_slot(int unsigned slot);
		longint unsigned span = longint'(STORE_WORDS) * 4;
		longint unsigned a;
		a = (longint'($urandom()) / span) * span + slot * 4 + $urandom_range(0, 3);
		return 32'(a);
	endfunction

	function automatic logic [31:0] random_entry();
		logic [31:0] w = $urandom();
		w[ENT_V] = ($urandom_range(0, 99) < 85);
		return w;
	endfunction

	// table walk predictor; returns 1 when the item yields a response
	function automatic bit apply_walk(logic cmd, logic [31:0] va, logic [31:0] word,
		logic wr, output walk_result_t res);
		int unsigned lslot;
		logic [31:0] pde;
		logic [31:0] pte;
		res = '0;
		if (cmd == CMD_LOAD) begin
			table_mirror[slot_of(va)] = word;
			slot_loaded[slot_of(va)] = 1'b1;
			return 1'b0;
		end
		pde = table_mirror[slot_of(dir_addr_of(root_mirror, va))];
		if (!pde[ENT_V]) begin
			res.fault = FAULT_DIR;
		end else begin
			lslot = slot_of(leaf_addr_of(pde, va));
			pte = table_mirror[lslot];
			if (!pte[ENT_V]) begin
				res.fault = FAULT_LEAF;
			end else begin
				if (!pte[ENT_A] || (wr && !pte[ENT_D])) begin
					pte[ENT_A] = 1'b1;
					if (wr)
						pte[ENT_D] = 1'b1;
					table_mirror[lslot] = pte;
					res.updated = 1'b1;
				end
				res.frame = pte[PPN_LSB +: FRAME_W];
			end
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("tb: mismatch on response %0d: %s got 0x%0h want 0x%0h",
				responses_seen, what, got, want);
	endtask

	task automatic drive_req(logic cmd, logic [31:0] va, logic [31:0] word, logic wr,
		bit typed = 1'b0, walk_result_t want = '0);
		walk_result_t res;
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.virtual_address <= va;
		req_ch.table_word <= word;
		req_ch.store_op <= wr;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_sent++;
		if (apply_walk(cmd, va, word, wr, res))
			pending_walks.push_back(typed ? want : res);
	endtask

	task automatic release_req();
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	task automatic settle();
		while (pending_walks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_root(logic [19:0] root);
		release_req();
		settle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.root_page_number <= root;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		root_mirror = root;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// never let a walk touch a store word that was not loaded yet
	task automatic ensure_walkable(logic [31:0] va);
		int unsigned dslot;
		int unsigned lslot;
		dslot = slot_of(dir_addr_of(root_mirror, va));
		if (!slot_loaded[dslot])
			drive_req(CMD_LOAD, addr_for_slot(dslot), random_entry(), $urandom_range(0, 1));
		if (table_mirror[dslot][ENT_V]) begin
			lslot = slot_of(leaf_addr_of(table_mirror[dslot], va));
			if (!slot_loaded[lslot])
				drive_req(CMD_LOAD, addr_for_slot(lslot), random_entry(),
					$urandom_range(0, 1));
		end
	endtask

	task automatic translate(logic [31:0] va, logic wr);
		ensure_walkable(va);
		drive_req(CMD_XLATE, va, $urandom(), wr);
	endtask

	// fresh directory entry, usually a fresh leaf, then a few walks through them
	task automatic walk_sequence();
		logic [31:0] va;
		int unsigned dslot;
		va = $urandom();
		dslot = slot_of(dir_addr_of(root_mirror, va));
		drive_req(CMD_LOAD, addr_for_slot(dslot), $urandom() | 32'h1, $urandom_range(0, 1));
		if ($urandom_range(0, 99) < 80)
			drive_req(CMD_LOAD, addr_for_slot(slot_of(leaf_addr_of(table_mirror[dslot], va))),
				random_entry(), $urandom_range(0, 1));
		repeat ($urandom_range(1, 3))
			translate({va[31:12], 12'($urandom())}, $urandom_range(0, 1));
		recent_va.push_back(va);
		if (recent_va.size() > 16)
			void'(recent_va.pop_front());
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		walk_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			responses_seen++;
			if (pending_walks.size() == 0) begin
				report_mismatch("unexpected transfer, fault", rsp_ch.fault, 0);
			end else begin
				want = pending_walks.pop_front();
				if (rsp_ch.frame_number !== want.frame)
					report_mismatch("frame_number", rsp_ch.frame_number, want.frame);
				if (rsp_ch.fault !== want.fault)
					report_mismatch("fault", rsp_ch.fault, want.fault);
				if (rsp_ch.entry_updated !== want.updated)
					report_mismatch("entry_updated", rsp_ch.entry_updated, want.updated);
			end
		end
	end

	// response sink; one long hold-off lets the core back up into its input
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && responses_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int unsigned phase_goal;
		int unsigned pick;
		logic [19:0] next_root;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_LOAD;
		req_ch.virtual_address = '0;
		req_ch.table_word = '0;
		req_ch.store_op = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.root_page_number = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (probe_rows[i])
			drive_req(probe_rows[i].cmd, probe_rows[i].addr, probe_rows[i].word,
				probe_rows[i].wr, probe_rows[i].typed, probe_rows[i].want);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: next_root = 20'hFFFFF;
				2: next_root = 20'h00000;
				default: next_root = 20'($urandom());
			endcase
			set_root(next_root);
			calm = (p == 1);
			phase_goal = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < phase_goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 45)
					walk_sequence();
				else if (pick < 65)
					translate($urandom(), $urandom_range(0, 1));
				else if (pick < 85 && recent_va.size() != 0)
					translate({recent_va[$urandom_range(0, recent_va.size() - 1)][31:12],
						12'($urandom())}, $urandom_range(0, 1));
				else
					drive_req(CMD_LOAD, $urandom(), $urandom(), $urandom_range(0, 1));
			end
		end
		calm = 1'b0;

		release_req();
		settle();
		if (mismatches == 0 && pending_walks.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
